// File: sv/rfd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rfd_pkg
// Shared types and constants of the relay forward decision core.
// ----------------------------------------------------------------------------
package rfd_pkg;

  localparam logic [2:0] REG_OWN_NODE_ID        = 3'd0;
  localparam logic [2:0] REG_NUM_VEHICLES       = 3'd1;
  localparam logic [2:0] REG_MAX_DELAY_US       = 3'd2;
  localparam logic [2:0] REG_MAX_LOSS_PERCENT   = 3'd3;
  localparam logic [2:0] REG_FORWARD_ALL        = 3'd4;
  localparam logic [2:0] REG_NO_FORWARD         = 3'd5;
  localparam logic [2:0] REG_PACKET_INTERVAL_US = 3'd6;

  localparam logic [6:0] LOSS_SCALE = 7'd100;

  typedef struct packed {
    logic        has_rec;
    logic        rec_up;
    logic [7:0]  rec_dist;
    logic        src_up;
    logic        src_down;
    logic [7:0]  src_dist;
    logic [7:0]  source_id;
    logic [31:0] seq;
    logic [31:0] now;
    logic        delay_chk;
    logic        force_fwd;
    logic        kill_fwd;
  } cmd_t;

  typedef struct packed {
    logic [7:0]  source_id;
    logic [31:0] seq;
  } hist_t;

  typedef struct packed {
    logic        up;
    logic [7:0]  hops;
    logic [31:0] stamp;
  } nbr_t;

endpackage

// File: sv/rfd_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rfd_front
// Classifies an incoming packet against the configuration into a command.
// ----------------------------------------------------------------------------
module rfd_front (
  input  logic [7:0]    own_node_id,
  input  logic [8:0]    num_vehicles,
  input  logic [31:0]   max_delay_us,
  input  logic          forward_all,
  input  logic          no_forward,
  input  logic [31:0]   packet_interval_us,
  input  logic [7:0]    link_sender_id,
  input  logic [31:0]   tx_stamp_us,
  input  logic [31:0]   seq_number,
  input  logic [7:0]    source_id,
  input  logic [31:0]   origin_stamp_us,
  input  logic [31:0]   now_us,
  output rfd_pkg::cmd_t cmd
);

  logic [31:0] tx_age;
  logic [31:0] origin_age;
  logic [8:0]  last_idx;
  logic        end_node;

  assign tx_age     = now_us - tx_stamp_us;
  assign origin_age = now_us - origin_stamp_us;
  assign last_idx   = num_vehicles - 9'd1;
  assign end_node   = (own_node_id == 8'd0) ||
                      ((num_vehicles != 9'd0) && ({1'b0, own_node_id} == last_idx));

  always_comb begin
    cmd.has_rec   = link_sender_id != own_node_id;
    cmd.rec_up    = link_sender_id < own_node_id;
    cmd.rec_dist  = cmd.rec_up ? own_node_id - link_sender_id
                               : link_sender_id - own_node_id;
    cmd.src_up    = source_id < own_node_id;
    cmd.src_down  = source_id > own_node_id;
    cmd.src_dist  = cmd.src_up ? own_node_id - source_id : source_id - own_node_id;
    cmd.source_id = source_id;
    cmd.seq       = seq_number;
    cmd.now       = now_us;
    cmd.delay_chk = (max_delay_us != 32'd0) && (tx_age > max_delay_us);
    cmd.force_fwd = forward_all;
    cmd.kill_fwd  = end_node || (origin_age > packet_interval_us) || no_forward;
  end

endmodule

// File: sv/rfd_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rfd_queue
// Two-entry command queue between the front and back parts.
// ----------------------------------------------------------------------------
module rfd_queue (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  rfd_pkg::cmd_t wr_data,
  output logic          full,
  input  logic          pop,
  output rfd_pkg::cmd_t rd_data,
  output logic          empty
);

  rfd_pkg::cmd_t slots [2];
  logic          wr_ptr;
  logic          rd_ptr;
  logic [1:0]    count;
  logic          do_push;
  logic          do_pop;

  assign full    = count == 2'd2;
  assign empty   = count == 2'd0;
  assign rd_data = slots[rd_ptr];
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (do_push) begin
        wr_ptr <= !wr_ptr;
      end
      if (do_pop) begin
        rd_ptr <= !rd_ptr;
      end
      count <= count + {1'b0, do_push} - {1'b0, do_pop};
    end
  end

endmodule

// File: sv/rfd_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rfd_back
// Sequencer that updates the neighbor and history stores, scans them and
// forms the relay decision.
// ----------------------------------------------------------------------------
module rfd_back #(
  parameter int HISTORY_DEPTH  = 1024,
  parameter int NEIGHBOR_DEPTH = 64
) (
  input  logic          clk,
  input  logic          rst,
  input  logic [31:0]   max_delay_us,
  input  logic [6:0]    max_loss_percent,
  input  rfd_pkg::cmd_t q_data,
  input  logic          q_empty,
  output logic          q_pop,
  output logic          res_valid,
  input  logic          res_pop,
  output logic          forward,
  output logic [1:0]    reason,
  output logic [31:0]   missed_count,
  output logic [31:0]   span_count
);

  localparam int HW = $clog2(HISTORY_DEPTH);
  localparam int HF = $clog2(HISTORY_DEPTH + 1);
  localparam int NW = $clog2(NEIGHBOR_DEPTH);
  localparam int NF = $clog2(NEIGHBOR_DEPTH + 1);
  localparam logic [HF:0] H_DEPTH = (HF + 1)'(HISTORY_DEPTH);
  localparam logic [NF:0] N_DEPTH = (NF + 1)'(NEIGHBOR_DEPTH);
  localparam logic [HW-1:0] H_LAST = HW'(HISTORY_DEPTH - 1);
  localparam logic [NW-1:0] N_LAST = NW'(NEIGHBOR_DEPTH - 1);

  typedef enum logic [3:0] {
    ST_IDLE, ST_NBR_WR, ST_AGE_RD, ST_AGE, ST_HIST_WR, ST_HIST_SCAN,
    ST_NBR_SCAN, ST_MUL, ST_DONE
  } state_t;

  state_t          state;
  rfd_pkg::cmd_t   cmd;
  rfd_pkg::hist_t  hist_mem [HISTORY_DEPTH];
  rfd_pkg::nbr_t   nbr_mem  [NEIGHBOR_DEPTH];
  rfd_pkg::hist_t  hist_rd;
  rfd_pkg::nbr_t   nbr_rd;

  logic [HW-1:0] hist_head;
  logic [HF-1:0] hist_fill;
  logic [NW-1:0] nbr_head;
  logic [NF-1:0] nbr_fill;
  logic [HF-1:0] hidx;
  logic [HW-1:0] haddr;
  logic [NF-1:0] nidx;
  logic [NW-1:0] naddr;
  logic          rd_vld;
  logic [31:0]   span;
  logic [31:0]   missed;
  logic [31:0]   last;
  logic          first;
  logic          dfwd;
  logic [38:0]   prod_a;
  logic [38:0]   prod_b;

  // neighbor write slot after a drop when full
  logic          nbr_full;
  logic [NW-1:0] nbr_head_a;
  logic [NF-1:0] nbr_fill_a;
  logic [NF:0]   nbr_sum;
  logic [NF:0]   nbr_sum_w;
  logic [NW-1:0] nbr_slot;
  logic          nbr_we;
  rfd_pkg::nbr_t nbr_wd;
  logic [NW-1:0] nbr_ra;

  logic          hist_full;
  logic [HW-1:0] hist_head_a;
  logic [HF-1:0] hist_fill_a;
  logic [HF:0]   hist_sum;
  logic [HF:0]   hist_sum_w;
  logic [HW-1:0] hist_slot;
  logic          hist_we;
  rfd_pkg::hist_t hist_wd;

  logic [31:0]   age;
  logic [31:0]   gap;
  logic [31:0]   ref_seq;
  logic          h_issue;
  logic          n_issue;
  logic          dir_match;
  logic          nearer;
  logic          fresh;
  logic          loss;

  assign nbr_full   = {1'b0, nbr_fill} == N_DEPTH;
  assign nbr_head_a = nbr_full ? ((nbr_head == N_LAST) ? '0 : nbr_head + 1'b1) : nbr_head;
  assign nbr_fill_a = nbr_full ? nbr_fill - 1'b1 : nbr_fill;
  assign nbr_sum    = {1'b0, NF'(nbr_head_a)} + {1'b0, nbr_fill_a};
  assign nbr_sum_w  = (nbr_sum >= N_DEPTH) ? nbr_sum - N_DEPTH : nbr_sum;
  assign nbr_slot   = nbr_sum_w[NW-1:0];
  assign nbr_we     = (state == ST_NBR_WR) && cmd.has_rec;
  assign nbr_wd     = '{up: cmd.rec_up, hops: cmd.rec_dist, stamp: cmd.now};
  assign nbr_ra     = (state == ST_AGE_RD) ? nbr_head : naddr;

  assign hist_full   = {1'b0, hist_fill} == H_DEPTH;
  assign hist_head_a = hist_full ? ((hist_head == H_LAST) ? '0 : hist_head + 1'b1)
                                 : hist_head;
  assign hist_fill_a = hist_full ? hist_fill - 1'b1 : hist_fill;
  assign hist_sum    = {1'b0, HF'(hist_head_a)} + {1'b0, hist_fill_a};
  assign hist_sum_w  = (hist_sum >= H_DEPTH) ? hist_sum - H_DEPTH : hist_sum;
  assign hist_slot   = hist_sum_w[HW-1:0];
  assign hist_we     = state == ST_HIST_WR;
  assign hist_wd     = '{source_id: cmd.source_id, seq: cmd.seq};

  assign age       = cmd.now - nbr_rd.stamp;
  assign ref_seq   = first ? last : hist_rd.seq;
  assign gap       = hist_rd.seq - ref_seq;
  assign h_issue   = hidx < hist_fill;
  assign n_issue   = nidx < nbr_fill;
  assign dir_match = (nbr_rd.up && cmd.src_up) || (!nbr_rd.up && cmd.src_down);
  assign nearer    = nbr_rd.hops < cmd.src_dist;
  assign fresh     = age < max_delay_us;
  assign loss      = prod_a > prod_b;
  assign q_pop     = (state == ST_IDLE) && !q_empty;

  always_ff @(posedge clk) begin
    if (nbr_we) begin
      nbr_mem[nbr_slot] <= nbr_wd;
    end
    nbr_rd <= nbr_mem[nbr_ra];
  end

  always_ff @(posedge clk) begin
    if (hist_we) begin
      hist_mem[hist_slot] <= hist_wd;
    end
    hist_rd <= hist_mem[haddr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      hist_head <= '0;
      hist_fill <= '0;
      nbr_head  <= '0;
      nbr_fill  <= '0;
      res_valid <= 1'b0;
      rd_vld    <= 1'b0;
    end else begin
      if (res_pop && res_valid && (state != ST_DONE)) begin
        res_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (!q_empty) begin
            cmd   <= q_data;
            state <= ST_NBR_WR;
          end
        end
        ST_NBR_WR: begin
          if (cmd.has_rec) begin
            nbr_head <= nbr_head_a;
            nbr_fill <= nbr_fill_a + 1'b1;
          end
          state <= ST_AGE_RD;
        end
        ST_AGE_RD: begin
          state <= (nbr_fill == '0) ? ST_HIST_WR : ST_AGE;
        end
        ST_AGE: begin
          if ({1'b0, age} > {max_delay_us, 1'b0}) begin
            nbr_head <= (nbr_head == N_LAST) ? '0 : nbr_head + 1'b1;
            nbr_fill <= nbr_fill - 1'b1;
          end
          state <= ST_HIST_WR;
        end
        ST_HIST_WR: begin
          hist_head <= hist_head_a;
          hist_fill <= hist_fill_a + 1'b1;
          hidx      <= '0;
          haddr     <= hist_head_a;
          rd_vld    <= 1'b0;
          span      <= 32'd1;
          missed    <= 32'd0;
          first     <= 1'b0;
          state     <= ST_HIST_SCAN;
        end
        ST_HIST_SCAN: begin
          rd_vld <= h_issue;
          if (h_issue) begin
            hidx  <= hidx + 1'b1;
            haddr <= (haddr == H_LAST) ? '0 : haddr + 1'b1;
          end
          if (rd_vld && (hist_rd.source_id == cmd.source_id)) begin
            first <= 1'b1;
            last  <= hist_rd.seq;
            span  <= span + gap;
            if (gap > 32'd1) begin
              missed <= missed + gap - 32'd1;
            end
          end
          if (!h_issue && !rd_vld) begin
            nidx  <= '0;
            naddr <= nbr_head;
            dfwd  <= 1'b0;
            state <= ST_NBR_SCAN;
          end
        end
        ST_NBR_SCAN: begin
          rd_vld <= n_issue;
          if (n_issue) begin
            nidx  <= nidx + 1'b1;
            naddr <= (naddr == N_LAST) ? '0 : naddr + 1'b1;
          end
          if (rd_vld && cmd.delay_chk && dir_match && !(nearer && fresh)) begin
            dfwd <= 1'b1;
          end
          if (!n_issue && !rd_vld) begin
            state <= ST_MUL;
          end
        end
        ST_MUL: begin
          prod_a <= 39'(missed) * 39'(rfd_pkg::LOSS_SCALE);
          prod_b <= 39'(max_loss_percent) * 39'(span);
          state  <= ST_DONE;
        end
        ST_DONE: begin
          if (!res_valid || res_pop) begin
            forward      <= (dfwd || loss || cmd.force_fwd) && !cmd.kill_fwd;
            reason       <= {loss, dfwd};
            missed_count <= missed;
            span_count   <= span;
            res_valid    <= 1'b1;
            state        <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

// File: sv/relay_forward_decision_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// relay_forward_decision_core
// Relay decision per received packet from neighbor and history tracking.
// ----------------------------------------------------------------------------
// channel   direction  handshake           payload
// input     in         push / full         link_sender_id .. now_us
// result    out        empty / pop         forward, reason, missed_count, span_count
// config    in         cfg_valid/cfg_ready cfg_index, cfg_data
//
// one packet scans every history entry and every stored neighbor in turn,
// through the single read port of the history ring and of the neighbor store
// a two-entry queue takes new packets while the sequencer works
// reset clears the ring pointers and fill counts; stores need no clearing
// a waiting result stalls the sequencer only at its last step
// ----------------------------------------------------------------------------
module relay_forward_decision_core #(
  parameter int HISTORY_DEPTH  = 1024,
  parameter int NEIGHBOR_DEPTH = 64
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  output logic        full,
  input  logic [7:0]  link_sender_id,
  input  logic [31:0] tx_stamp_us,
  input  logic [31:0] seq_number,
  input  logic [7:0]  source_id,
  input  logic [31:0] origin_stamp_us,
  input  logic [31:0] now_us,
  output logic        empty,
  input  logic        pop,
  output logic        forward,
  output logic [1:0]  reason,
  output logic [31:0] missed_count,
  output logic [31:0] span_count,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_data
);

  logic [7:0]    own_node_id;
  logic [8:0]    num_vehicles;
  logic [31:0]   max_delay_us;
  logic [6:0]    max_loss_percent;
  logic          forward_all;
  logic          no_forward;
  logic [31:0]   packet_interval_us;
  rfd_pkg::cmd_t front_cmd;
  rfd_pkg::cmd_t q_data;
  logic          q_empty;
  logic          q_pop;
  logic          res_valid;

  assign cfg_ready = 1'b1;
  assign empty     = !res_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      own_node_id        <= 8'd0;
      num_vehicles       <= 9'd5;
      max_delay_us       <= 32'hFFFF_FFFF;
      max_loss_percent   <= 7'd100;
      forward_all        <= 1'b0;
      no_forward         <= 1'b0;
      packet_interval_us <= 32'd1000000;
    end else if (cfg_valid) begin
      case (cfg_index)
        rfd_pkg::REG_OWN_NODE_ID:        own_node_id        <= cfg_data[7:0];
        rfd_pkg::REG_NUM_VEHICLES:       num_vehicles       <= cfg_data[8:0];
        rfd_pkg::REG_MAX_DELAY_US:       max_delay_us       <= cfg_data;
        rfd_pkg::REG_MAX_LOSS_PERCENT:   max_loss_percent   <= cfg_data[6:0];
        rfd_pkg::REG_FORWARD_ALL:        forward_all        <= cfg_data[0];
        rfd_pkg::REG_NO_FORWARD:         no_forward         <= cfg_data[0];
        rfd_pkg::REG_PACKET_INTERVAL_US: packet_interval_us <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  rfd_front u_front (
    .own_node_id        (own_node_id),
    .num_vehicles       (num_vehicles),
    .max_delay_us       (max_delay_us),
    .forward_all        (forward_all),
    .no_forward         (no_forward),
    .packet_interval_us (packet_interval_us),
    .link_sender_id     (link_sender_id),
    .tx_stamp_us        (tx_stamp_us),
    .seq_number         (seq_number),
    .source_id          (source_id),
    .origin_stamp_us    (origin_stamp_us),
    .now_us             (now_us),
    .cmd                (front_cmd)
  );

  rfd_queue u_queue (
    .clk     (clk),
    .rst     (rst),
    .push    (push),
    .wr_data (front_cmd),
    .full    (full),
    .pop     (q_pop),
    .rd_data (q_data),
    .empty   (q_empty)
  );

  rfd_back #(
    .HISTORY_DEPTH  (HISTORY_DEPTH),
    .NEIGHBOR_DEPTH (NEIGHBOR_DEPTH)
  ) u_back (
    .clk              (clk),
    .rst              (rst),
    .max_delay_us     (max_delay_us),
    .max_loss_percent (max_loss_percent),
    .q_data           (q_data),
    .q_empty          (q_empty),
    .q_pop            (q_pop),
    .res_valid        (res_valid),
    .res_pop          (pop),
    .forward          (forward),
    .reason           (reason),
    .missed_count     (missed_count),
    .span_count       (span_count)
  );

endmodule
